### rtl/ihex_pkg.sv
// Shared types, constants and helpers of the Intel HEX record encoder.
package ihex_pkg;

  localparam int unsigned MaxRecordDefault = 32;
  localparam int unsigned LenW             = 8;
  localparam int unsigned LimitW           = 6;
  localparam logic [LimitW-1:0] LimitReset = 6'd32;

  localparam logic [7:0] TypeData = 8'h00;
  localparam logic [7:0] TypeEof  = 8'h01;
  localparam logic [7:0] TypeEsa  = 8'h02;
  localparam logic [7:0] EsaLen   = 8'd2;
  localparam logic [7:0] EofLen   = 8'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] hi_char;
    logic [6:0] lo_char;
    logic       record_start;
    logic       record_end;
    logic       run_last;
  } out_item_t;

  // One classified input byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0]      data_byte;
    logic [LenW-1:0] wr_idx;
    logic            flush;
    logic [LenW-1:0] len;
    logic [15:0]     offset;
    logic            esa;
    logic [3:0]      seg;
    logic            eof;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_OFF_HI,
    ST_OFF_LO,
    ST_TYPE,
    ST_DATA,
    ST_CSUM
  } back_state_e;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_ESA,
    KIND_EOF
  } rec_kind_e;

  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] nib_w;
    nib_w = {3'b000, nib};
    return (nib < 4'd10) ? (7'h30 + nib_w) : (7'h37 + nib_w);
  endfunction

endpackage

### rtl/ihex_front.sv
// Front end: takes image bytes, tracks fill, offset and segment, decides record flushes.
module ihex_front
  import ihex_pkg::*;
#(
  parameter int unsigned MAX_RECORD = MaxRecordDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  localparam int unsigned FW = $clog2(MAX_RECORD + 1);
  localparam int unsigned CW = (FW > LimitW) ? FW : LimitW;

  logic [LimitW-1:0] limit_q;
  logic [FW-1:0]     fill_q, fill_d, fill_nxt;
  logic [15:0]       offset_q, offset_d;
  logic [3:0]        seg_q, seg_d;
  logic [CW-1:0]     lim_ext, lim_eff;
  logic [16:0]       end_pos;
  logic              at_boundary, flush, accept;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i & cmd_ready_i;

  assign fill_nxt = fill_q + FW'(1);
  assign lim_ext  = CW'(limit_q);

  always_comb begin
    if (lim_ext == '0) begin
      lim_eff = CW'(1);
    end else if (lim_ext > CW'(MAX_RECORD)) begin
      lim_eff = CW'(MAX_RECORD);
    end else begin
      lim_eff = lim_ext;
    end
  end

  assign end_pos     = {1'b0, offset_q} + 17'(fill_nxt);
  assign at_boundary = end_pos[16];
  assign flush       = (CW'(fill_nxt) >= lim_eff) | at_boundary | in_data_i.last_byte;

  always_comb begin
    cmd_o.data_byte = in_data_i.data_byte;
    cmd_o.wr_idx    = LenW'(fill_q);
    cmd_o.flush     = flush;
    cmd_o.len       = LenW'(fill_nxt);
    cmd_o.offset    = offset_q;
    cmd_o.esa       = at_boundary;
    cmd_o.seg       = seg_q + 4'd1;
    cmd_o.eof       = in_data_i.last_byte;
  end

  always_comb begin
    fill_d   = fill_q;
    offset_d = offset_q;
    seg_d    = seg_q;
    if (accept) begin
      if (in_data_i.last_byte) begin
        fill_d   = '0;
        offset_d = '0;
        seg_d    = '0;
      end else if (flush) begin
        fill_d = '0;
        if (at_boundary) begin
          seg_d    = seg_q + 4'd1;
          offset_d = '0;
        end else begin
          offset_d = end_pos[15:0];
        end
      end else begin
        fill_d = fill_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LimitReset;
      fill_q   <= '0;
      offset_q <= '0;
      seg_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      fill_q   <= fill_d;
      offset_q <= offset_d;
      seg_q    <= seg_d;
    end
  end

endmodule

### rtl/ihex_fifo.sv
// Two-entry command queue between the front and back ends.
module ihex_fifo
  import ihex_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count did not advance on push");

endmodule

### rtl/ihex_back.sv
// Back end: record buffer and record sequencer, one record byte per output transfer.
module ihex_back
  import ihex_pkg::*;
#(
  parameter int unsigned MAX_RECORD = MaxRecordDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned IW = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;

  logic [7:0] buf_q [MAX_RECORD];
  logic [7:0] rd_q;

  back_state_e     state_q, state_d;
  rec_kind_e       kind_q, kind_d;
  logic [LenW-1:0] len_q, cnt_q, cnt_d, cur_len, cnt_inc;
  logic [15:0]     offset_q;
  logic            esa_q, eof_q;
  logic [3:0]      seg_q;
  logic [7:0]      sum_q, sum_d;
  out_item_t       out_q;
  logic            out_valid_q;

  logic       adv, emit, take, rd_en, more;
  logic [7:0] byte_val, type_val;
  logic       first_flag, end_flag;
  logic [IW-1:0] rd_addr;

  assign adv         = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign take        = cmd_valid_i & cmd_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cnt_inc     = cnt_q + LenW'(1);

  always_comb begin
    case (kind_q)
      KIND_DATA: begin
        cur_len  = len_q;
        type_val = TypeData;
      end
      KIND_ESA: begin
        cur_len  = EsaLen;
        type_val = TypeEsa;
      end
      default: begin
        cur_len  = EofLen;
        type_val = TypeEof;
      end
    endcase
  end

  assign more = ((kind_q == KIND_DATA) && (esa_q || eof_q)) || ((kind_q == KIND_ESA) && eof_q);

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cnt_d      = cnt_q;
    byte_val   = 8'h00;
    first_flag = 1'b0;
    end_flag   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (take && cmd_i.flush) begin
          state_d = ST_LEN;
          kind_d  = KIND_DATA;
        end
      end
      ST_LEN: begin
        byte_val   = cur_len;
        first_flag = 1'b1;
        if (adv) begin
          state_d = ST_OFF_HI;
        end
      end
      ST_OFF_HI: begin
        byte_val = (kind_q == KIND_DATA) ? offset_q[15:8] : 8'h00;
        if (adv) begin
          state_d = ST_OFF_LO;
        end
      end
      ST_OFF_LO: begin
        byte_val = (kind_q == KIND_DATA) ? offset_q[7:0] : 8'h00;
        if (adv) begin
          state_d = ST_TYPE;
        end
      end
      ST_TYPE: begin
        byte_val = type_val;
        if (adv) begin
          cnt_d   = '0;
          rd_en   = (kind_q == KIND_DATA);
          state_d = (cur_len == '0) ? ST_CSUM : ST_DATA;
        end
      end
      ST_DATA: begin
        if (kind_q == KIND_DATA) begin
          byte_val = rd_q;
        end else begin
          byte_val = (cnt_q == '0) ? {seg_q, 4'h0} : 8'h00;
        end
        if (adv) begin
          if (cnt_inc == cur_len) begin
            state_d = ST_CSUM;
          end else begin
            cnt_d   = cnt_inc;
            rd_en   = (kind_q == KIND_DATA);
            rd_addr = cnt_inc[IW-1:0];
          end
        end
      end
      ST_CSUM: begin
        byte_val = 8'h00 - sum_q;
        end_flag = 1'b1;
        if (adv) begin
          if (kind_q == KIND_DATA && esa_q) begin
            kind_d  = KIND_ESA;
            state_d = ST_LEN;
          end else if (kind_q != KIND_EOF && eof_q) begin
            kind_d  = KIND_EOF;
            state_d = ST_LEN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign emit  = adv && (state_q != ST_IDLE);
  assign sum_d = (state_q == ST_LEN) ? byte_val : (sum_q + byte_val);

  // Record buffer: written as bytes drain from the queue, read one byte ahead of output.
  always_ff @(posedge clk_i) begin
    if (take) begin
      buf_q[cmd_i.wr_idx[IW-1:0]] <= cmd_i.data_byte;
    end
    if (rd_en) begin
      rd_q <= buf_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.flush) begin
      len_q    <= cmd_i.len;
      offset_q <= cmd_i.offset;
      esa_q    <= cmd_i.esa;
      eof_q    <= cmd_i.eof;
      seg_q    <= cmd_i.seg;
    end
    if (emit) begin
      sum_q              <= sum_d;
      out_q.hi_char      <= hex_digit(byte_val[7:4]);
      out_q.lo_char      <= hex_digit(byte_val[3:0]);
      out_q.record_start <= first_flag;
      out_q.record_end   <= end_flag;
      out_q.run_last     <= end_flag && !more;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_DATA;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.run_last) |-> out_q.record_end)
    else $error("run_last outside a checksum byte");

  a_start_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.record_start) |-> !out_q.record_end)
    else $error("length byte flagged as checksum");

  a_data_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |-> (cnt_q < cur_len))
    else $error("data index beyond record length");

  a_quiet_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !cmd_i.flush) |=> (state_q == ST_IDLE))
    else $error("non-flushing byte started a record");

endmodule

### rtl/intel_hex_record_encoder.sv
// Top level of the Intel HEX record encoder: front end, command queue, back end.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one image byte per
//   transfer, with last_byte set on the final byte of the image. Output channel
//   (out_valid_o/out_ready_i/out_data_o) carries one record byte per transfer as
//   two ASCII hex digits, flagged for the leading colon, the trailing newline and
//   the final result caused by an input byte.
//   cfg_we_i/cfg_wdata_i write record_limit (1..MAX_RECORD bytes per data record); the
//   user must write it only while the block is idle, the block does not enforce it. Reset value is 32.
// Timing:
//   Bytes enter a two-entry queue one per cycle while it has room. The back end stores
//   one byte per cycle while idle, then sends one record byte per cycle while the receiver
//   takes them: 5 + n bytes for a data record of n bytes, 7 for a segment record, 5 for
//   the end-of-file record. A byte closing a record, queue empty and back end idle,
//   passes the queue, the back-end state and output registers before out_valid_o rises.
//   The back end stores every byte before it sends the record bytes one by one.
// Reset: clears fill count, offset, segment and the queue; the record buffer is
//   not cleared. A stalled receiver holds the output register and the back end,
//   the queue fills and in_ready_o drops.
module intel_hex_record_encoder
  import ihex_pkg::*;
#(
  parameter int unsigned MAX_RECORD = MaxRecordDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  ihex_front #(
    .MAX_RECORD(MAX_RECORD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  ihex_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i (f_cmd),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_data_o (b_cmd)
  );

  ihex_back #(
    .MAX_RECORD(MAX_RECORD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(b_valid),
    .cmd_ready_o(b_ready),
    .cmd_i      (b_cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
